// ===== hw/rtl/wsc_pkg.sv =====
`default_nettype none

package wsc_pkg;

    localparam int WAVE_BYTES     = 16;
    localparam int PERIOD_SPAN    = 2048;
    localparam int LENGTH_MAX_DEF = 256;

    localparam int KIND_W   = 3;
    localparam int SEL_W    = 3;
    localparam int ADDR_W   = $clog2(WAVE_BYTES);
    localparam int DATA_W   = 8;
    localparam int SAMPLE_W = 4;
    localparam int POS_W    = ADDR_W + 1;
    localparam int PERIOD_W = $clog2(PERIOD_SPAN);
    localparam int PCNT_W   = PERIOD_W + 1;
    localparam int VOL_W    = 2;

    localparam logic [KIND_W-1:0] KIND_REG_WR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REG_RD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WAVE_WR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WAVE_RD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LEN     = 3'd5;
    localparam logic [KIND_W-1:0] KIND_POWER   = 3'd6;

    localparam logic [SEL_W-1:0] SEL_DAC    = 3'd0;
    localparam logic [SEL_W-1:0] SEL_LENGTH = 3'd1;
    localparam logic [SEL_W-1:0] SEL_VOLUME = 3'd2;
    localparam logic [SEL_W-1:0] SEL_PER_LO = 3'd3;
    localparam logic [SEL_W-1:0] SEL_PER_HI = 3'd4;

    localparam logic [DATA_W-1:0] RD_DAC_MASK = 8'h7F;
    localparam logic [DATA_W-1:0] RD_VOL_MASK = 8'b1001_1111;
    localparam logic [DATA_W-1:0] RD_CTL_MASK = 8'b1011_1111;
    localparam logic [DATA_W-1:0] RD_OPEN     = 8'hFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_DAC_OFF = 4'b0111;

endpackage

`default_nettype wire

// ===== hw/rtl/wavetable_sound_channel.sv =====
// Wavetable sound channel: 32 four-bit samples in a 16-byte wave store.
// Request channel: i_in_valid / o_in_stall with i_kind, i_reg_select,
// i_wave_addr and i_write_data. Each request is a register write or read,
// a wave store write or read, a channel tick, a length tick or a power clear.
// Result channel: o_out_valid / i_out_stall with o_read_data, o_sample_out
// and o_channel_on, one result per request, in request order.
// Throughput is one request per cycle while i_out_stall stays low. The accept
// edge updates the control state and reads the wave store RAM (synchronous
// read) into the middle stage; the result register then captures the result
// after the fetched nibble and the volume shift.
// When i_out_stall is high the result register holds; the middle stage then
// fills and o_in_stall rises, so at most two requests are in flight.
// Reset (i_rst_n low, synchronous) empties the pipeline, restores the control
// state and marks every wave store byte unwritten, which reads as 255; no
// clearing pass is needed.
`default_nettype none

module wavetable_sound_channel #(
    parameter int LENGTH_MAX = wsc_pkg::LENGTH_MAX_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [wsc_pkg::KIND_W-1:0]     i_kind,
    input  wire  [wsc_pkg::SEL_W-1:0]      i_reg_select,
    input  wire  [wsc_pkg::ADDR_W-1:0]     i_wave_addr,
    input  wire  [wsc_pkg::DATA_W-1:0]     i_write_data,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [wsc_pkg::DATA_W-1:0]     o_read_data,
    output logic [wsc_pkg::SAMPLE_W-1:0]   o_sample_out,
    output logic                           o_channel_on
);

    localparam int LEN_W     = $clog2(LENGTH_MAX + 1);
    localparam int MOD_STEPS = 255 / LENGTH_MAX;
    localparam int DEPTH     = wsc_pkg::WAVE_BYTES;
    localparam int AW        = wsc_pkg::ADDR_W;
    localparam int DW        = wsc_pkg::DATA_W;
    localparam int PW        = wsc_pkg::PERIOD_W;
    localparam int CW        = wsc_pkg::PCNT_W;
    localparam int QW        = wsc_pkg::POS_W;
    localparam int VW        = wsc_pkg::VOL_W;
    localparam int SW        = wsc_pkg::SAMPLE_W;

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_wv;
    logic [DW-1:0]    r_mem_q;
    logic             r_mem_vld;

    logic          r_dac, n_dac;
    logic [VW-1:0] r_vol, n_vol;
    logic [PW-1:0] r_period, n_period;
    logic          r_len_en, n_len_en;
    logic [LEN_W-1:0] r_len, n_len;
    logic [CW-1:0] r_pcnt, n_pcnt;
    logic [QW-1:0] r_pos, n_pos;
    logic          r_playing, n_playing;
    logic [SW-1:0] r_nibble;

    logic          r_s1_valid;
    logic          r_s1_reload;
    logic          r_s1_odd;
    logic          r_s1_from_mem;
    logic [DW-1:0] r_s1_rd;
    logic          r_s1_dac;
    logic          r_s1_play;
    logic [VW-1:0] r_s1_vol;

    logic          r_out_valid;
    logic [DW-1:0] r_out_rd;
    logic [SW-1:0] r_out_sample;
    logic          r_out_on;

    logic          acc;
    logic          out_free;
    logic          s1_free;
    logic          s1_adv;
    logic          wave_wr;
    logic [AW-1:0] rd_addr;
    logic          reload;
    logic [DW-1:0] rd_now;
    logic          from_mem;
    logic [8:0]    len_mod;
    logic [DW-1:0] s1_byte;
    logic [SW-1:0] s1_nibble;
    logic [SW-1:0] s1_sample;
    logic [DW-1:0] s1_read;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = !s1_free;
    assign acc        = i_in_valid && s1_free;

    assign wave_wr = acc && (i_kind == wsc_pkg::KIND_WAVE_WR) && !r_playing;
    assign rd_addr = (i_kind == wsc_pkg::KIND_WAVE_RD) ? i_wave_addr : r_pos[QW-1:1];
    assign reload  = (i_kind == wsc_pkg::KIND_TICK) && (r_pcnt <= CW'(1));

    always_comb begin
        len_mod = {1'b0, i_write_data};
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (len_mod >= 9'(LENGTH_MAX)) begin
                len_mod = len_mod - 9'(LENGTH_MAX);
            end
        end
    end

    always_comb begin
        n_dac     = r_dac;
        n_vol     = r_vol;
        n_period  = r_period;
        n_len_en  = r_len_en;
        n_len     = r_len;
        n_pcnt    = r_pcnt;
        n_pos     = r_pos;
        n_playing = r_playing;
        rd_now    = '0;
        from_mem  = 1'b0;
        unique case (i_kind)
            wsc_pkg::KIND_REG_WR: begin
                unique case (i_reg_select)
                    wsc_pkg::SEL_DAC: begin
                        n_dac = i_write_data[7];
                        if (!i_write_data[7]) begin
                            n_playing = 1'b0;
                        end
                    end
                    wsc_pkg::SEL_LENGTH: n_len = LEN_W'(9'(LENGTH_MAX) - len_mod);
                    wsc_pkg::SEL_VOLUME: n_vol = i_write_data[6:5];
                    wsc_pkg::SEL_PER_LO: n_period = {r_period[PW-1:8], i_write_data};
                    wsc_pkg::SEL_PER_HI: begin
                        n_period = {i_write_data[2:0], r_period[7:0]};
                        n_len_en = i_write_data[6];
                        if (i_write_data[7]) begin
                            n_playing = r_dac;
                            if (r_len == '0) begin
                                n_len = LEN_W'(LENGTH_MAX);
                            end
                            n_pcnt = CW'(wsc_pkg::PERIOD_SPAN) - {1'b0, n_period};
                            n_pos  = '0;
                        end
                    end
                    default: ;
                endcase
            end
            wsc_pkg::KIND_REG_RD: begin
                unique case (i_reg_select)
                    wsc_pkg::SEL_DAC:    rd_now = {r_dac, 7'd0} | wsc_pkg::RD_DAC_MASK;
                    wsc_pkg::SEL_VOLUME: rd_now = {1'b0, r_vol, 5'd0} | wsc_pkg::RD_VOL_MASK;
                    wsc_pkg::SEL_PER_HI: rd_now = {1'b0, r_len_en, 6'd0} | wsc_pkg::RD_CTL_MASK;
                    default:             rd_now = wsc_pkg::RD_OPEN;
                endcase
            end
            wsc_pkg::KIND_WAVE_RD: begin
                from_mem = !r_playing;
                rd_now   = wsc_pkg::RD_OPEN;
            end
            wsc_pkg::KIND_TICK: begin
                if (reload) begin
                    n_pcnt = CW'(wsc_pkg::PERIOD_SPAN) - {1'b0, r_period};
                    n_pos  = r_pos + QW'(1);
                end else begin
                    n_pcnt = r_pcnt - CW'(1);
                end
            end
            wsc_pkg::KIND_LEN: begin
                if (r_len_en && (r_len != '0)) begin
                    n_len = r_len - LEN_W'(1);
                    if (r_len == LEN_W'(1)) begin
                        n_playing = 1'b0;
                    end
                end
            end
            wsc_pkg::KIND_POWER: begin
                n_dac     = 1'b0;
                n_playing = 1'b0;
                n_vol     = '0;
                n_period  = '0;
                n_len_en  = 1'b0;
                n_pos     = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wave_wr) begin
            r_mem[i_wave_addr] <= i_write_data;
        end
        if (acc) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv      <= '0;
            r_mem_vld <= 1'b0;
        end else begin
            if (wave_wr) begin
                r_wv[i_wave_addr] <= 1'b1;
            end
            if (acc) begin
                r_mem_vld <= r_wv[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dac     <= 1'b0;
            r_vol     <= '0;
            r_period  <= PW'(wsc_pkg::PERIOD_SPAN - 1);
            r_len_en  <= 1'b0;
            r_len     <= LEN_W'(1);
            r_pcnt    <= CW'(1);
            r_pos     <= '0;
            r_playing <= 1'b0;
        end else if (acc) begin
            r_dac     <= n_dac;
            r_vol     <= n_vol;
            r_period  <= n_period;
            r_len_en  <= n_len_en;
            r_len     <= n_len;
            r_pcnt    <= n_pcnt;
            r_pos     <= n_pos;
            r_playing <= n_playing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_reload   <= reload;
            r_s1_odd      <= r_pos[0];
            r_s1_from_mem <= from_mem;
            r_s1_rd       <= rd_now;
            r_s1_dac      <= n_dac;
            r_s1_play     <= n_playing;
            r_s1_vol      <= n_vol;
        end
    end

    assign s1_byte   = r_mem_vld ? r_mem_q : wsc_pkg::RD_OPEN;
    assign s1_read   = r_s1_from_mem ? s1_byte : r_s1_rd;
    assign s1_nibble = !r_s1_reload ? r_nibble : (r_s1_odd ? s1_byte[3:0] : s1_byte[7:4]);

    always_comb begin
        if (!r_s1_dac) begin
            s1_sample = wsc_pkg::SAMPLE_DAC_OFF;
        end else if (!r_s1_play || (r_s1_vol == '0)) begin
            s1_sample = '0;
        end else begin
            s1_sample = s1_nibble >> (r_s1_vol - VW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_nibble    <= '0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= acc;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_nibble    <= s1_nibble;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_rd     <= s1_read;
            r_out_sample <= s1_sample;
            r_out_on     <= r_s1_play;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_out_rd;
    assign o_sample_out = r_out_sample;
    assign o_channel_on = r_out_on;

    a_play_needs_dac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> r_dac)
        else $error("channel playing with dac off");

    a_play_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> (r_len != '0))
        else $error("channel playing with expired length");

    a_pcnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt != '0)
        else $error("period timer reached zero");

    a_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_kind == wsc_pkg::KIND_REG_WR) && (i_reg_select == wsc_pkg::SEL_PER_HI)
            && i_write_data[7])
        |=> (r_pos == '0) && (r_len != '0))
        else $error("trigger did not restart position and length");

    a_blocked_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_kind == wsc_pkg::KIND_WAVE_WR) && r_playing) |=> $stable(r_wv))
        else $error("wave store written while playing");

endmodule

`default_nettype wire
